FILE: rtl/bwse_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package bwse_pkg;

    localparam int ID_W      = 11;
    localparam int BYTE_W    = 8;
    localparam int CMD_W     = 2;
    localparam int CLASS_W   = 2;
    localparam int KEY_W     = 2 * ID_W;
    localparam int BYTE_TOKENS = 256;

    typedef logic [CMD_W-1:0] cmd_t;
    localparam cmd_t CMD_RULE  = 2'd0;
    localparam cmd_t CMD_BYTE  = 2'd1;
    localparam cmd_t CMD_FLUSH = 2'd2;

    typedef logic [CLASS_W-1:0] class_t;
    localparam class_t CLS_SPACE  = 2'd0;
    localparam class_t CLS_LETTER = 2'd1;
    localparam class_t CLS_DIGIT  = 2'd2;
    localparam class_t CLS_OTHER  = 2'd3;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_SCAN,
        ST_DRAIN,
        ST_DECIDE,
        ST_EMIT,
        ST_POST
    } state_t;

    // byte class: whitespace, letter, digit, other
    function automatic class_t byte_class(input logic [BYTE_W-1:0] c);
        class_t cls;
        if (c == 8'h20 || (c >= 8'h09 && c <= 8'h0D))
            cls = CLS_SPACE;
        else if ((c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A))
            cls = CLS_LETTER;
        else if (c >= 8'h30 && c <= 8'h39)
            cls = CLS_DIGIT;
        else
            cls = CLS_OTHER;
        return cls;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/bwse_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module bwse_ram #(
    parameter int WIDTH = 22,
    parameter int DEPTH = 1024,
    parameter int AW    = 10
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    addr,
    input  logic [WIDTH-1:0] wdata,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // single port, registered read
    always_ff @(posedge clk)
    begin
        if (we)
            mem[addr] <= wdata;
        rdata <= mem[addr];
    end

endmodule

`default_nettype wire

FILE: rtl/bwse_pair_match.sv
`timescale 1ns / 1ps
`default_nettype none

module bwse_pair_match #(
    parameter int MAX_WORD = 32,
    parameter int LW = 6,
    parameter int IW = 5
) (
    input  logic [bwse_pkg::ID_W-1:0]  word [MAX_WORD],
    input  logic [LW-1:0]              len,
    input  logic [bwse_pkg::KEY_W-1:0] key,
    input  logic [MAX_WORD-1:0]        found,
    output logic [MAX_WORD-1:0]        match,
    output logic                       hit,
    output logic [IW-1:0]              pos
);
    import bwse_pkg::*;

    // compare one rule against every adjacent pair not yet ranked
    always_comb
    begin
        match = '0;
        for (int i = 0; i < MAX_WORD - 1; i++)
        begin
            if ((LW'(i + 1) < len) && !found[i] && key == {word[i], word[i + 1]})
                match[i] = 1'b1;
        end
    end

    // leftmost hit
    always_comb
    begin
        pos = '0;
        for (int i = MAX_WORD - 1; i >= 0; i--)
        begin
            if (match[i])
                pos = IW'(i);
        end
        hit = |match;
    end

endmodule

`default_nettype wire

FILE: rtl/bpe_word_split_encoder_core.sv
`timescale 1ns / 1ps
`default_nettype none

// Byte pair encoding word encoder. Rule words (command 0) load a merge table;
// text bytes group into words of one byte class and a word is encoded when
// it ends (class change, MAX_WORD bytes, or flush). Encoding a word of n
// bytes runs up to n-1 merge passes; each pass reads the whole merge table
// once, newest rule first, through a single RAM read port and compares every
// rule against all adjacent pairs at once. Tokens then leave at one per cycle
// while out_ready is high. The input side is not ready while a word is being
// encoded or emitted.
module bpe_word_split_encoder_core #(
    parameter int MAX_MERGES = 1024,
    parameter int MAX_WORD   = 32
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [bwse_pkg::CMD_W-1:0]  command,
    input  logic [bwse_pkg::ID_W-1:0]   left_id,
    input  logic [bwse_pkg::ID_W-1:0]   right_id,
    input  logic [bwse_pkg::BYTE_W-1:0] text_byte,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [bwse_pkg::ID_W-1:0]   token_id,
    output logic                        last_of_word
);
    import bwse_pkg::*;

    localparam int AW = (MAX_MERGES > 1) ? $clog2(MAX_MERGES) : 1;
    localparam int CW = $clog2(MAX_MERGES + 1);
    localparam int LW = $clog2(MAX_WORD + 1);
    localparam int IW = $clog2(MAX_WORD);

    state_t state_reg, state_next;

    logic [CW-1:0]     cnt_reg, cnt_next;
    logic [LW-1:0]     len_reg, len_next;
    class_t            cls_reg, cls_next;
    logic              pend_reg, pend_next;
    logic [BYTE_W-1:0] byte_reg, byte_next;
    logic [AW-1:0]     idx_reg, idx_next;
    logic              rd_vld_reg, rd_vld_next;
    logic [AW-1:0]     rd_rank_reg, rd_rank_next;
    logic [MAX_WORD-1:0] found_reg, found_next;
    logic              best_hit_reg, best_hit_next;
    logic [IW-1:0]     best_pos_reg, best_pos_next;
    logic [AW-1:0]     best_rank_reg, best_rank_next;
    logic [LW-1:0]     eidx_reg, eidx_next;
    logic              out_valid_reg, out_valid_next;
    logic [ID_W-1:0]   token_reg, token_next;
    logic              last_reg, last_next;

    logic [ID_W-1:0]   word_reg [MAX_WORD];
    logic [ID_W-1:0]   word_next [MAX_WORD];

    logic              ram_we;
    logic [AW-1:0]     ram_addr;
    logic [KEY_W-1:0]  ram_q;

    logic [MAX_WORD-1:0] match;
    logic                m_hit;
    logic [IW-1:0]       m_pos;

    logic              accept;
    class_t            in_cls;
    logic              closes_word;
    logic              load_out;
    logic              emit_last;
    logic [ID_W-1:0]   merged_id;

    assign in_ready     = (state_reg == ST_IDLE);
    assign accept       = in_valid && in_ready;
    assign in_cls       = byte_class(text_byte);
    assign closes_word  = (len_reg != '0) &&
                          (in_cls != cls_reg || len_reg >= LW'(MAX_WORD));
    assign load_out     = !out_valid_reg || out_ready;
    assign emit_last    = (LW'(eidx_reg + 1'b1) == len_reg);
    assign merged_id    = ID_W'(32'(BYTE_TOKENS) + 32'(best_rank_reg));

    assign out_valid    = out_valid_reg;
    assign token_id     = token_reg;
    assign last_of_word = last_reg;

    // merge table
    assign ram_we   = accept && command == CMD_RULE && cnt_reg < CW'(MAX_MERGES);
    assign ram_addr = (state_reg == ST_IDLE) ? cnt_reg[AW-1:0] : idx_reg;

    bwse_ram #(
        .WIDTH (KEY_W),
        .DEPTH (MAX_MERGES),
        .AW    (AW)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata ({left_id, right_id}),
        .rdata (ram_q)
    );

    // pair compare unit
    bwse_pair_match #(
        .MAX_WORD (MAX_WORD),
        .LW       (LW),
        .IW       (IW)
    ) u_match (
        .word  (word_reg),
        .len   (len_reg),
        .key   (ram_q),
        .found (found_reg),
        .match (match),
        .hit   (m_hit),
        .pos   (m_pos)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (command == CMD_BYTE && closes_word)
                        state_next = ST_CHECK;
                    else if (command == CMD_FLUSH && len_reg != '0)
                        state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                if (len_reg >= LW'(2) && cnt_reg != '0)
                    state_next = ST_SCAN;
                else
                    state_next = ST_EMIT;
            end
            ST_SCAN:
            begin
                if (idx_reg == '0)
                    state_next = ST_DRAIN;
            end
            ST_DRAIN:  state_next = ST_DECIDE;
            ST_DECIDE:
            begin
                if (best_hit_reg)
                    state_next = ST_CHECK;
                else
                    state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (load_out && emit_last)
                    state_next = ST_POST;
            end
            ST_POST:   state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    // datapath
    always_comb
    begin
        cnt_next       = cnt_reg;
        len_next       = len_reg;
        cls_next       = cls_reg;
        pend_next      = pend_reg;
        byte_next      = byte_reg;
        idx_next       = idx_reg;
        rd_vld_next    = rd_vld_reg;
        rd_rank_next   = rd_rank_reg;
        found_next     = found_reg;
        best_hit_next  = best_hit_reg;
        best_pos_next  = best_pos_reg;
        best_rank_next = best_rank_reg;
        eidx_next      = eidx_reg;
        out_valid_next = out_valid_reg;
        token_next     = token_reg;
        last_next      = last_reg;
        word_next      = word_reg;

        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;

        // compare the rule read in the previous cycle
        if ((state_reg == ST_SCAN || state_reg == ST_DRAIN) && rd_vld_reg)
        begin
            found_next = found_reg | match;
            if (m_hit)
            begin
                best_hit_next  = 1'b1;
                best_pos_next  = m_pos;
                best_rank_next = rd_rank_reg;
            end
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (command == CMD_RULE)
                    begin
                        if (ram_we)
                            cnt_next = cnt_reg + 1'b1;
                    end
                    else if (command == CMD_BYTE)
                    begin
                        cls_next = in_cls;
                        if (closes_word)
                        begin
                            pend_next = 1'b1;
                            byte_next = text_byte;
                        end
                        else
                        begin
                            word_next[len_reg[IW-1:0]] = ID_W'(text_byte);
                            len_next = len_reg + 1'b1;
                        end
                    end
                    else if (command == CMD_FLUSH)
                    begin
                        pend_next = 1'b0;
                    end
                end
            end
            ST_CHECK:
            begin
                idx_next      = AW'(cnt_reg - 1'b1);
                rd_vld_next   = 1'b0;
                found_next    = '0;
                best_hit_next = 1'b0;
                eidx_next     = '0;
            end
            ST_SCAN:
            begin
                rd_vld_next  = 1'b1;
                rd_rank_next = idx_reg;
                if (idx_reg != '0)
                    idx_next = idx_reg - 1'b1;
            end
            ST_DRAIN:
            begin
                rd_vld_next = 1'b0;
            end
            ST_DECIDE:
            begin
                // replace the best pair and close the gap
                if (best_hit_reg)
                begin
                    for (int i = 0; i < MAX_WORD; i++)
                    begin
                        if (IW'(i) == best_pos_reg)
                            word_next[i] = merged_id;
                        else if (IW'(i) > best_pos_reg && i < MAX_WORD - 1)
                            word_next[i] = word_reg[i + 1];
                    end
                    len_next = len_reg - 1'b1;
                end
            end
            ST_EMIT:
            begin
                if (load_out)
                begin
                    out_valid_next = 1'b1;
                    token_next     = word_reg[eidx_reg[IW-1:0]];
                    last_next      = emit_last;
                    eidx_next      = eidx_reg + 1'b1;
                end
            end
            ST_POST:
            begin
                if (pend_reg)
                begin
                    word_next[0] = ID_W'(byte_reg);
                    len_next     = LW'(1);
                end
                else
                begin
                    len_next = '0;
                end
                pend_next = 1'b0;
            end
            default: ;
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            len_reg       <= '0;
            cls_reg       <= CLS_SPACE;
            pend_reg      <= 1'b0;
            rd_vld_reg    <= 1'b0;
            best_hit_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            len_reg       <= len_next;
            cls_reg       <= cls_next;
            pend_reg      <= pend_next;
            rd_vld_reg    <= rd_vld_next;
            best_hit_reg  <= best_hit_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        byte_reg      <= byte_next;
        idx_reg       <= idx_next;
        rd_rank_reg   <= rd_rank_next;
        found_reg     <= found_next;
        best_pos_reg  <= best_pos_next;
        best_rank_reg <= best_rank_next;
        eidx_reg      <= eidx_next;
        token_reg     <= token_next;
        last_reg      <= last_next;
        word_reg      <= word_next;
    end

endmodule

`default_nettype wire
